[src/acd_pkg.sv]
// ----------------------------------------------------------------------------
// acd_pkg
// Types and fixed constants shared by the allpass cascade decorrelator.
// ----------------------------------------------------------------------------
package acd_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int COEF_W      = 24;
   localparam int PROD_W      = 48;
   localparam int ACC_W       = 56;
   localparam int ROUND_SHIFT = 22;
   localparam int LENF_W      = 11;
   localparam int STAGEF_W    = 4;
   localparam int CFG_W       = 5;
   localparam int REQ_DATA_W  = 112;
   localparam int REQ_USER_W  = 2;

   // unity weight in Q2.22
   localparam logic signed [COEF_W-1:0] UNITY_COEF = 24'sh400000;
   localparam logic signed [ACC_W-1:0]  ROUND_BIAS = 56'sd2097152;
   localparam logic signed [ACC_W-1:0]  SAT_HI_ACC = 56'sd8388607;
   localparam logic signed [ACC_W-1:0]  SAT_LO_ACC = -56'sd8388608;
   localparam logic signed [SAMPLE_W-1:0] SAT_HI  = 24'sd8388607;
   localparam logic signed [SAMPLE_W-1:0] SAT_LO  = -24'sd8388608;

   localparam logic [CFG_W-1:0] STAGES_RESET = 5'd6;

   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_LOAD   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MAC,
      ST_WRITE,
      ST_DONE
   } state_type;

   // product terms in issue order; the last code only drains the product
   typedef enum logic [2:0] {
      TERM_B1_X,
      TERM_B0_XH0,
      TERM_A1_XH2,
      TERM_U_XH1,
      TERM_A1_YH0,
      TERM_B0_YH2,
      TERM_B1_YH1,
      TERM_FLUSH
   } term_type;

   typedef struct packed {
      logic clear;
      logic issue;
      logic sub;
   } mac_ctl_type;

endpackage

[src/acd_mac.sv]
// ----------------------------------------------------------------------------
// acd_mac
// Shared multiply-accumulate unit with Q3.45 to Q1.23 round and saturate.
// ----------------------------------------------------------------------------
module acd_mac (
   input  logic                                     clock,
   input  logic                                     reset,
   input  acd_pkg::mac_ctl_type                     ctl,
   input  logic signed [acd_pkg::COEF_W-1:0]        coef,
   input  logic signed [acd_pkg::SAMPLE_W-1:0]      sample,
   output logic signed [acd_pkg::SAMPLE_W-1:0]      result
);

   logic signed [acd_pkg::PROD_W-1:0] prod_ff;
   logic                              sub_ff;
   logic                              pv_ff;
   logic signed [acd_pkg::ACC_W-1:0]  acc_ff;
   logic signed [acd_pkg::ACC_W-1:0]  prod_ext;
   logic signed [acd_pkg::ACC_W-1:0]  rnd_sum;
   logic signed [acd_pkg::ACC_W-1:0]  quot;

   always_ff @(posedge clock) begin
      if (ctl.issue) begin
         prod_ff <= coef * sample;
         sub_ff  <= ctl.sub;
      end
   end

   assign prod_ext = acd_pkg::ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff  <= 1'b0;
         acc_ff <= '0;
      end else if (ctl.clear) begin
         pv_ff  <= 1'b0;
         acc_ff <= '0;
      end else begin
         pv_ff <= ctl.issue;
         if (pv_ff) begin
            acc_ff <= sub_ff ? acc_ff - prod_ext : acc_ff + prod_ext;
         end
      end
   end

   // add half, floor
   assign rnd_sum = acc_ff + acd_pkg::ROUND_BIAS;
   assign quot    = rnd_sum >>> acd_pkg::ROUND_SHIFT;

   always_comb begin
      if (quot > acd_pkg::SAT_HI_ACC) begin
         result = acd_pkg::SAT_HI;
      end else if (quot < acd_pkg::SAT_LO_ACC) begin
         result = acd_pkg::SAT_LO;
      end else begin
         result = quot[acd_pkg::SAMPLE_W-1:0];
      end
   end

endmodule

[src/allpass_cascade_decorrelator.sv]
// ----------------------------------------------------------------------------
// allpass_cascade_decorrelator
// Per-channel cascade of delay-line allpass stages on Q1.23 audio samples.
// ----------------------------------------------------------------------------
// The req channel carries one word per item. A sample word (tuser action 0)
// runs its channel through the first stages_in_use stages and yields one rsp
// word; a load word (tuser action 1) sets one stage's b0, b1, a1 and line
// length, restarts its pointer and empties its history, and yields nothing.
// A load completes in the accept cycle. For each enabled stage a sample runs
// through history reads, the product terms in turn through the single shared
// multiplier-accumulator and a write-back to the history lines; after the
// last stage it goes to the output register. req_tready is low while
// a sample is in work. History entries are tracked by pointer and a per-stage
// wrap flag, so reset and loads need no clearing sweep; after reset all
// tables hold their reset values and history reads as zero. The result sits
// in an output register; while rsp is stalled a new item may still be taken,
// and a finished sample holds in its last step until the register frees.
// csr_we writes stages_in_use at once; write it only while idle.
// ----------------------------------------------------------------------------
module allpass_cascade_decorrelator #(
   parameter int CHANNEL_COUNT = 2,
   parameter int STAGE_LIMIT   = 16,
   parameter int LINE_DEPTH    = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [23:0] sample_in, [27:24] stage_index, [51:28] coef_b0, [75:52] coef_b1,
   // [99:76] coef_a1, [110:100] line_length, [111] zero
   input  logic [acd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] action, [1] channel
   input  logic [acd_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [23:0] sample_out
   output logic [acd_pkg::SAMPLE_W-1:0]       rsp_tdata,
   // [0] out_channel
   output logic                               rsp_tuser,
   input  logic                               csr_we,
   input  logic [acd_pkg::CFG_W-1:0]          csr_wdata
);

   localparam int SLOTS     = CHANNEL_COUNT * STAGE_LIMIT;
   localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int IDX_W     = $clog2(LINE_DEPTH);
   localparam int LEN_W     = $clog2(LINE_DEPTH + 1);
   localparam int CMP_W     = (LEN_W > acd_pkg::LENF_W) ? LEN_W : acd_pkg::LENF_W;
   localparam int ADDR_W    = SLOT_W + IDX_W;
   localparam int MEM_DEPTH = 2 ** ADDR_W;
   localparam int CNT_W     = $clog2(STAGE_LIMIT + 1);

   // request fields
   logic                                  f_action;
   logic                                  f_channel;
   logic signed [acd_pkg::SAMPLE_W-1:0]   f_sample;
   logic [acd_pkg::STAGEF_W-1:0]          f_stage;
   logic signed [acd_pkg::COEF_W-1:0]     f_b0;
   logic signed [acd_pkg::COEF_W-1:0]     f_b1;
   logic signed [acd_pkg::COEF_W-1:0]     f_a1;
   logic [acd_pkg::LENF_W-1:0]            f_len;

   assign f_action  = req_tuser[0];
   assign f_channel = req_tuser[1];
   assign f_sample  = req_tdata[23:0];
   assign f_stage   = req_tdata[27:24];
   assign f_b0      = req_tdata[51:28];
   assign f_b1      = req_tdata[75:52];
   assign f_a1      = req_tdata[99:76];
   assign f_len     = req_tdata[110:100];

   // state
   acd_pkg::state_type                    state_ff, state_in;
   logic [2:0]                            step_ff, step_in;
   logic [CNT_W-1:0]                      stage_ff;
   logic                                  ch_ff;
   logic signed [acd_pkg::SAMPLE_W-1:0]   x_ff;
   logic [acd_pkg::CFG_W-1:0]             stages_ff;

   logic signed [acd_pkg::COEF_W-1:0]     b0_ff [SLOTS];
   logic signed [acd_pkg::COEF_W-1:0]     b1_ff [SLOTS];
   logic signed [acd_pkg::COEF_W-1:0]     a1_ff [SLOTS];
   logic [LEN_W-1:0]                      len_ff [SLOTS];
   logic [IDX_W-1:0]                      ptr_ff [SLOTS];
   logic                                  wrap_ff [SLOTS];

   logic signed [acd_pkg::SAMPLE_W-1:0]   xhist_mem [MEM_DEPTH];
   logic signed [acd_pkg::SAMPLE_W-1:0]   yhist_mem [MEM_DEPTH];
   logic signed [acd_pkg::SAMPLE_W-1:0]   xrd_ff, yrd_ff;
   logic signed [acd_pkg::SAMPLE_W-1:0]   xh0_ff, xh1_ff, xh2_ff;
   logic signed [acd_pkg::SAMPLE_W-1:0]   yh0_ff, yh1_ff, yh2_ff;

   logic                                  rsp_valid_ff;
   logic [acd_pkg::SAMPLE_W-1:0]          rsp_data_ff;
   logic                                  rsp_ch_ff;

   // decode
   logic                                  req_fire;
   logic                                  ch_ok;
   logic                                  start;
   logic                                  do_load;
   logic [SLOT_W-1:0]                     ld_slot;
   logic [CMP_W-1:0]                      len_wide;
   logic [LEN_W-1:0]                      len_clamped;
   logic [acd_pkg::CFG_W-1:0]             n_eff;
   logic                                  last_stage;

   logic [SLOT_W-1:0]                     cur_slot;
   logic [IDX_W-1:0]                      cur_p;
   logic [LEN_W-1:0]                      cur_len;
   logic [IDX_W-1:0]                      idx_prev;
   logic [IDX_W-1:0]                      idx_next;
   logic                                  at_end;
   logic                                  v_prev, v_next, v_cur;
   logic [IDX_W-1:0]                      rd_idx;
   logic [ADDR_W-1:0]                     rd_addr;
   logic [ADDR_W-1:0]                     wr_addr;

   acd_pkg::term_type                     term;
   acd_pkg::mac_ctl_type                  mac_ctl;
   logic signed [acd_pkg::COEF_W-1:0]     mac_coef;
   logic signed [acd_pkg::SAMPLE_W-1:0]   mac_sample;
   logic signed [acd_pkg::SAMPLE_W-1:0]   mac_y;

   logic                                  hist_we;
   logic                                  rsp_load;

   assign req_fire = req_tvalid && req_tready;
   assign ch_ok    = {3'b000, f_channel} < 4'(CHANNEL_COUNT);
   assign start    = req_fire && ch_ok && (f_action == acd_pkg::ACT_SAMPLE);
   assign do_load  = req_fire && ch_ok && (f_action == acd_pkg::ACT_LOAD) &&
                     ({1'b0, f_stage} < 5'(STAGE_LIMIT));
   assign ld_slot  = (f_channel ? SLOT_W'(STAGE_LIMIT) : SLOT_W'(0)) + SLOT_W'(f_stage);

   always_comb begin
      len_wide = CMP_W'(f_len);
      if (len_wide < CMP_W'(2)) begin
         len_clamped = LEN_W'(2);
      end else if (len_wide > CMP_W'(LINE_DEPTH)) begin
         len_clamped = LEN_W'(LINE_DEPTH);
      end else begin
         len_clamped = len_wide[LEN_W-1:0];
      end
   end

   always_comb begin
      if (stages_ff == '0) begin
         n_eff = 5'd1;
      end else if (stages_ff > 5'(STAGE_LIMIT)) begin
         n_eff = 5'(STAGE_LIMIT);
      end else begin
         n_eff = stages_ff;
      end
   end

   assign last_stage = (5'(stage_ff) == (n_eff - 5'd1));

   // per-stage addressing
   assign cur_slot = (ch_ff ? SLOT_W'(STAGE_LIMIT) : SLOT_W'(0)) + SLOT_W'(stage_ff);
   assign cur_p    = ptr_ff[cur_slot];
   assign cur_len  = len_ff[cur_slot];
   assign at_end   = (LEN_W'(cur_p) + LEN_W'(1)) >= cur_len;
   assign idx_prev = (cur_p == '0) ? IDX_W'(cur_len - LEN_W'(1)) : cur_p - IDX_W'(1);
   assign idx_next = at_end ? '0 : cur_p + IDX_W'(1);
   // entries below the pointer are written since the load; all once wrapped
   assign v_prev   = wrap_ff[cur_slot] || (cur_p != '0);
   assign v_next   = wrap_ff[cur_slot] || at_end;
   assign v_cur    = wrap_ff[cur_slot];

   always_comb begin
      case (step_ff)
         3'd0:    rd_idx = idx_prev;
         3'd1:    rd_idx = idx_next;
         default: rd_idx = cur_p;
      endcase
   end

   assign rd_addr = {cur_slot, rd_idx};
   assign wr_addr = {cur_slot, cur_p};

   // history lines
   always_ff @(posedge clock) begin
      if (hist_we) begin
         xhist_mem[wr_addr] <= x_ff;
      end
      xrd_ff <= xhist_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         yhist_mem[wr_addr] <= mac_y;
      end
      yrd_ff <= yhist_mem[rd_addr];
   end

   // capture taps, masking entries not yet written
   always_ff @(posedge clock) begin
      if (state_ff == acd_pkg::ST_READ) begin
         case (step_ff)
            3'd1: begin
               xh0_ff <= v_prev ? xrd_ff : '0;
               yh0_ff <= v_prev ? yrd_ff : '0;
            end
            3'd2: begin
               xh2_ff <= v_next ? xrd_ff : '0;
               yh2_ff <= v_next ? yrd_ff : '0;
            end
            3'd3: begin
               xh1_ff <= v_cur ? xrd_ff : '0;
               yh1_ff <= v_cur ? yrd_ff : '0;
            end
            default: begin
            end
         endcase
      end
   end

   // operand select
   assign term = acd_pkg::term_type'(step_ff);

   always_comb begin
      case (term)
         acd_pkg::TERM_B1_X: begin
            mac_coef = b1_ff[cur_slot]; mac_sample = x_ff;
         end
         acd_pkg::TERM_B0_XH0: begin
            mac_coef = b0_ff[cur_slot]; mac_sample = xh0_ff;
         end
         acd_pkg::TERM_A1_XH2: begin
            mac_coef = a1_ff[cur_slot]; mac_sample = xh2_ff;
         end
         acd_pkg::TERM_U_XH1: begin
            mac_coef = acd_pkg::UNITY_COEF; mac_sample = xh1_ff;
         end
         acd_pkg::TERM_A1_YH0: begin
            mac_coef = a1_ff[cur_slot]; mac_sample = yh0_ff;
         end
         acd_pkg::TERM_B0_YH2: begin
            mac_coef = b0_ff[cur_slot]; mac_sample = yh2_ff;
         end
         acd_pkg::TERM_B1_YH1: begin
            mac_coef = b1_ff[cur_slot]; mac_sample = yh1_ff;
         end
         default: begin
            mac_coef = '0; mac_sample = '0;
         end
      endcase
   end

   acd_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .coef   (mac_coef),
      .sample (mac_sample),
      .result (mac_y)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         acd_pkg::ST_IDLE: begin
            if (start) state_in = acd_pkg::ST_READ;
         end
         acd_pkg::ST_READ: begin
            if (step_ff == 3'd3) state_in = acd_pkg::ST_MAC;
         end
         acd_pkg::ST_MAC: begin
            if (step_ff == 3'd7) state_in = acd_pkg::ST_WRITE;
         end
         acd_pkg::ST_WRITE: begin
            state_in = last_stage ? acd_pkg::ST_DONE : acd_pkg::ST_READ;
         end
         acd_pkg::ST_DONE: begin
            if (rsp_load) state_in = acd_pkg::ST_IDLE;
         end
         default: state_in = acd_pkg::ST_IDLE;
      endcase
   end

   assign step_in = (state_in != state_ff) ? 3'd0 : step_ff + 3'd1;

   // outputs of the sequencer
   always_comb begin
      req_tready    = 1'b0;
      mac_ctl.clear = 1'b0;
      mac_ctl.issue = 1'b0;
      mac_ctl.sub   = 1'b0;
      hist_we       = 1'b0;
      rsp_load      = 1'b0;
      case (state_ff)
         acd_pkg::ST_IDLE:  req_tready = 1'b1;
         acd_pkg::ST_READ:  mac_ctl.clear = (step_ff == 3'd3);
         acd_pkg::ST_MAC: begin
            mac_ctl.issue = (term != acd_pkg::TERM_FLUSH);
            mac_ctl.sub   = (term == acd_pkg::TERM_A1_YH0) ||
                            (term == acd_pkg::TERM_B0_YH2) ||
                            (term == acd_pkg::TERM_B1_YH1);
         end
         acd_pkg::ST_WRITE: hist_we = 1'b1;
         acd_pkg::ST_DONE:  rsp_load = !rsp_valid_ff || rsp_tready;
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= acd_pkg::ST_IDLE;
         step_ff   <= '0;
         stages_ff <= acd_pkg::STAGES_RESET;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (csr_we) begin
            stages_ff <= csr_wdata;
         end
      end
   end

   // working sample and stage count
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff     <= f_sample;
         ch_ff    <= f_channel;
         stage_ff <= '0;
      end else if (hist_we) begin
         x_ff <= mac_y;
         if (!last_stage) begin
            stage_ff <= stage_ff + CNT_W'(1);
         end
      end
   end

   // stage tables
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            b0_ff[i]   <= '0;
            b1_ff[i]   <= '0;
            a1_ff[i]   <= '0;
            len_ff[i]  <= LEN_W'(2);
            ptr_ff[i]  <= '0;
            wrap_ff[i] <= 1'b0;
         end
      end else if (do_load) begin
         b0_ff[ld_slot]   <= f_b0;
         b1_ff[ld_slot]   <= f_b1;
         a1_ff[ld_slot]   <= f_a1;
         len_ff[ld_slot]  <= len_clamped;
         ptr_ff[ld_slot]  <= '0;
         wrap_ff[ld_slot] <= 1'b0;
      end else if (hist_we) begin
         ptr_ff[cur_slot] <= idx_next;
         if (at_end) begin
            wrap_ff[cur_slot] <= 1'b1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= x_ff;
         rsp_ch_ff   <= ch_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ch_ff;

endmodule

[src/acd_checker.sv]
// ----------------------------------------------------------------------------
// acd_checker
// Port-level checks on the allpass cascade decorrelator.
// ----------------------------------------------------------------------------
module acd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [acd_pkg::REQ_USER_W-1:0]     req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [acd_pkg::SAMPLE_W-1:0]       rsp_tdata,
   input logic                               rsp_tuser
);

   // stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp word changed");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // a channel-0 sample word occupies the unit
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == acd_pkg::ACT_SAMPLE) && !req_tuser[1]
      |=> !req_tready)
      else $error("sample accepted without going busy");

   // a result only appears out of a sample in work
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("rsp word without work");

endmodule

bind allpass_cascade_decorrelator acd_checker u_acd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
